FILE: hw/rtl/csl_pkg.sv
// Shared types and constants for the counter sequence link checker.
`timescale 1ns / 1ps
package csl_pkg;

   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W  = 32;

   // register indexes on the configuration channel
   localparam logic [CSR_INDEX_W-1:0] CSR_ACK_WINDOW  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_QUIET_LIMIT = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEAD_LIMIT  = 2'd2;

   localparam logic [15:0] ACK_WINDOW_RESET  = 16'd0;
   localparam logic [31:0] QUIET_LIMIT_RESET = 32'd300000;
   localparam logic [31:0] DEAD_LIMIT_RESET  = 32'd5000000;

   // a stamp is retaken whenever the byte count is a multiple of 64
   localparam int unsigned STAMP_BITS = 6;

   localparam logic KIND_BYTE  = 1'b0;
   localparam logic KIND_TICK  = 1'b1;
   localparam logic REPORT_ACK = 1'b0;
   localparam logic REPORT_END = 1'b1;

   typedef struct packed {
      logic [15:0] ack_window;
      logic [31:0] quiet_limit;
      logic [31:0] dead_limit;
   } csl_cfg_type;

   typedef struct packed {
      logic        report_kind;
      logic [31:0] total_bytes;
      logic [31:0] elapsed_ticks;
      logic [31:0] mismatches;
   } csl_result_type;

endpackage

FILE: hw/rtl/csl_req_if.sv
// Request channel: received byte or timebase tick.
`timescale 1ns / 1ps
interface csl_req_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [7:0] rx_byte;

   modport source (output valid, output kind, output rx_byte, input ready);
   modport sink   (input valid, input kind, input rx_byte, output ready);
endinterface

FILE: hw/rtl/csl_rsp_if.sv
// Result channel: window acknowledges and end of run reports.
`timescale 1ns / 1ps
interface csl_rsp_if;
   logic        valid;
   logic        ready;
   logic        report_kind;
   logic [31:0] total_bytes;
   logic [31:0] elapsed_ticks;
   logic [31:0] mismatches;

   modport source (output valid, output report_kind, output total_bytes,
                   output elapsed_ticks, output mismatches, input ready);
   modport sink   (input valid, input report_kind, input total_bytes,
                   input elapsed_ticks, input mismatches, output ready);
endinterface

FILE: hw/rtl/csl_csr_if.sv
// Configuration write channel.
`timescale 1ns / 1ps
interface csl_csr_if;
   logic                             valid;
   logic                             ready;
   logic [csl_pkg::CSR_INDEX_W-1:0]  index;
   logic [csl_pkg::CSR_DATA_W-1:0]   data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: hw/rtl/csl_cfg_regs.sv
// Configuration registers: window and idle limits.
`timescale 1ns / 1ps
module csl_cfg_regs (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            wr_en,
   input  logic [csl_pkg::CSR_INDEX_W-1:0] wr_index,
   input  logic [csl_pkg::CSR_DATA_W-1:0]  wr_data,
   output csl_pkg::csl_cfg_type            cfg
);

   csl_pkg::csl_cfg_type cfg_ff;
   csl_pkg::csl_cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (wr_index)
            csl_pkg::CSR_ACK_WINDOW:  cfg_in.ack_window  = wr_data[15:0];
            csl_pkg::CSR_QUIET_LIMIT: cfg_in.quiet_limit = wr_data;
            csl_pkg::CSR_DEAD_LIMIT:  cfg_in.dead_limit  = wr_data;
            default:                  cfg_in = cfg_ff;   // unused index
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ack_window  <= csl_pkg::ACK_WINDOW_RESET;
         cfg_ff.quiet_limit <= csl_pkg::QUIET_LIMIT_RESET;
         cfg_ff.dead_limit  <= csl_pkg::DEAD_LIMIT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: hw/rtl/csl_run_tracker.sv
// Run state: sequence check, counters, stamps, window and idle detection.
`timescale 1ns / 1ps
module csl_run_tracker (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     item_en,
   input  logic                     kind,
   input  logic [7:0]               rx_byte,
   input  csl_pkg::csl_cfg_type     cfg,
   output logic                     res_valid,
   output csl_pkg::csl_result_type  res
);

   logic [7:0]  expected_ff,  expected_in;
   logic [31:0] bytes_ff,     bytes_in;
   logic [31:0] mism_ff,      mism_in;
   logic [15:0] progress_ff,  progress_in;
   logic [31:0] time_ff,      time_in;
   logic [31:0] first_ff,     first_in;
   logic [31:0] last_ff,      last_in;

   logic [31:0] bytes_inc;
   logic [15:0] progress_inc;
   logic [31:0] time_inc;
   logic [31:0] idle;
   logic [31:0] limit;

   assign bytes_inc    = bytes_ff + 32'd1;
   assign progress_inc = progress_ff + 16'd1;
   assign time_inc     = time_ff + 32'd1;
   assign idle         = time_inc - last_ff;
   assign limit        = (bytes_ff != 32'd0) ? cfg.quiet_limit : cfg.dead_limit;

   always_comb begin
      expected_in = expected_ff;
      bytes_in    = bytes_ff;
      mism_in     = mism_ff;
      progress_in = progress_ff;
      time_in     = time_ff;
      first_in    = first_ff;
      last_in     = last_ff;
      res_valid   = 1'b0;
      res.report_kind   = csl_pkg::REPORT_ACK;
      res.total_bytes   = bytes_inc;
      res.elapsed_ticks = 32'd0;
      res.mismatches    = 32'd0;

      if (item_en) begin
         if (kind == csl_pkg::KIND_BYTE) begin
            if (rx_byte != expected_ff) begin
               mism_in = mism_ff + 32'd1;
            end
            expected_in = rx_byte + 8'd1;
            bytes_in    = bytes_inc;
            if (bytes_inc == 32'd1) begin
               first_in = time_ff;
               last_in  = time_ff;
            end else if (bytes_inc[csl_pkg::STAMP_BITS-1:0] == '0) begin
               last_in = time_ff;
            end
            if (cfg.ack_window != 16'd0) begin
               if (progress_inc >= cfg.ack_window) begin
                  progress_in = 16'd0;
                  res_valid   = 1'b1;
               end else begin
                  progress_in = progress_inc;
               end
            end
         end else begin
            time_in = time_inc;
            if (idle > limit) begin
               res_valid         = 1'b1;
               res.report_kind   = csl_pkg::REPORT_END;
               res.total_bytes   = bytes_ff;
               res.elapsed_ticks = last_ff - first_ff;
               res.mismatches    = mism_ff;
               // clear the run; time keeps counting
               expected_in = 8'd0;
               bytes_in    = 32'd0;
               mism_in     = 32'd0;
               progress_in = 16'd0;
               first_in    = 32'd0;
               last_in     = time_inc;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         expected_ff <= 8'd0;
         bytes_ff    <= 32'd0;
         mism_ff     <= 32'd0;
         progress_ff <= 16'd0;
         time_ff     <= 32'd0;
         first_ff    <= 32'd0;
         last_ff     <= 32'd0;
      end else begin
         expected_ff <= expected_in;
         bytes_ff    <= bytes_in;
         mism_ff     <= mism_in;
         progress_ff <= progress_in;
         time_ff     <= time_in;
         first_ff    <= first_in;
         last_ff     <= last_in;
      end
   end

endmodule

FILE: hw/rtl/csl_out_stage.sv
// Result register with valid/ready toward the receiver.
`timescale 1ns / 1ps
module csl_out_stage (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     load_en,
   input  logic                     load_valid,
   input  csl_pkg::csl_result_type  load_data,
   input  logic                     out_ready,
   output logic                     out_valid,
   output csl_pkg::csl_result_type  out_data,
   output logic                     can_load
);

   logic                     valid_ff, valid_in;
   csl_pkg::csl_result_type  data_ff,  data_in;

   // free when empty or when the held result leaves this cycle
   assign can_load = !valid_ff || out_ready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (load_en) begin
         valid_in = load_valid;
         data_in  = load_data;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

FILE: hw/rtl/counter_sequence_link_checker_top.sv
// Top level of the counter sequence link checker.
`timescale 1ns / 1ps
// Checks a received byte stream that should count up by one, modulo 256.
// req_ch carries one request per handshake: a received byte (kind 0) or one
// microsecond timebase tick (kind 1). rsp_ch carries window acknowledges
// (report_kind 0, byte count only) and end of run reports (report_kind 1,
// byte count, ticks between first and last stamp, mismatch count).
// csr_ch writes ack_window (index 0), quiet_limit (1) and dead_limit (2);
// other indexes are dropped. Writes are always taken; change them only while
// no request is in flight.
// Latency: a result shows on rsp_ch the cycle after its request is taken.
// Throughput: one request per cycle while req_ch.ready is high (see Stall);
// the per-request work is a short chain of 32-bit increment, subtract and
// compare in front of the run state and result register.
// A request that makes no result still reloads the result register and leaves it empty.
// Stall: the result register accepts a new request whenever it is empty or
// its result is taken in the same cycle, so req_ch.ready drops only while a
// result waits and rsp_ch.ready is low.
// Reset (synchronous, active high) clears the run state, the time counter
// and the result register, and loads the register reset values.
module counter_sequence_link_checker_top (
   input  logic       clock,
   input  logic       reset,
   csl_req_if.sink    req_ch,
   csl_rsp_if.source  rsp_ch,
   csl_csr_if.sink    csr_ch
);

   csl_pkg::csl_cfg_type     cfg;
   csl_pkg::csl_result_type  res;
   csl_pkg::csl_result_type  out_data;
   logic                     res_valid;
   logic                     can_load;
   logic                     req_fire;

   assign csr_ch.ready = 1'b1;
   assign req_ch.ready = can_load;
   assign req_fire     = req_ch.valid && can_load;

   csl_cfg_regs u_cfg (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_ch.valid),
      .wr_index (csr_ch.index),
      .wr_data  (csr_ch.data),
      .cfg      (cfg)
   );

   csl_run_tracker u_tracker (
      .clock     (clock),
      .reset     (reset),
      .item_en   (req_fire),
      .kind      (req_ch.kind),
      .rx_byte   (req_ch.rx_byte),
      .cfg       (cfg),
      .res_valid (res_valid),
      .res       (res)
   );

   // a taken request always reloads the result register, empty or not
   csl_out_stage u_out (
      .clock      (clock),
      .reset      (reset),
      .load_en    (req_fire),
      .load_valid (res_valid),
      .load_data  (res),
      .out_ready  (rsp_ch.ready),
      .out_valid  (rsp_ch.valid),
      .out_data   (out_data),
      .can_load   (can_load)
   );

   assign rsp_ch.report_kind   = out_data.report_kind;
   assign rsp_ch.total_bytes   = out_data.total_bytes;
   assign rsp_ch.elapsed_ticks = out_data.elapsed_ticks;
   assign rsp_ch.mismatches    = out_data.mismatches;

endmodule

FILE: bench/tb_counter_sequence_link_checker_top.sv
// Self-checking testbench for the counter sequence link checker top level.
`timescale 1ns / 1ps
module tb_counter_sequence_link_checker_top;
   import csl_pkg::*;

   // index 3 is not a register: the block must drop writes to it
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE = 2'd3;
   localparam logic [31:0] LIMIT_MAX = 32'hFFFF_FFFF;
   localparam int unsigned RANDOM_REQS = 1800;
   // longest receiver hold-off; the watchdog limit sits far above it plus any
   // sender gap, receiver stall and the result register of the block
   localparam int unsigned LONG_HOLD = 400;
   localparam int unsigned WATCHDOG_LIMIT = 5000;

   typedef struct packed {
      logic       kind;
      logic [7:0] rx_byte;
   } csl_req_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   csl_req_if req_ch ();
   csl_rsp_if rsp_ch ();
   csl_csr_if csr_ch ();

   counter_sequence_link_checker_top dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // ---------------------------------------------------------------------
   // Predicted checker state: register copies plus the run bookkeeping.
   // Starts at the reset values; reset is applied exactly once.
   // ---------------------------------------------------------------------
   csl_cfg_type cfg_model = '{ack_window:  ACK_WINDOW_RESET,
                              quiet_limit: QUIET_LIMIT_RESET,
                              dead_limit:  DEAD_LIMIT_RESET};
   logic [7:0]  next_byte  = '0;   // value the incrementing pattern expects
   logic [31:0] run_bytes  = '0;
   logic [31:0] run_bad    = '0;
   logic [15:0] win_fill   = '0;   // bytes since the last window acknowledge
   logic [31:0] now_us     = '0;   // free-running tick count, never cleared
   logic [31:0] first_mark = '0;
   logic [31:0] last_mark  = '0;

   csl_req_type    pending_reqs[$];   // requests waiting to be offered
   csl_result_type reports_due[$];    // predicted reports, oldest first
   int unsigned    reqs_queued = 0;
   int unsigned    error_count = 0;

   // Advances the predicted state by one request; returns 1 when the request
   // produces a report, which is then left in rep.
   function automatic bit predict_report(input csl_req_type r, output csl_result_type rep);
      logic [31:0] idle;
      bit          run_over;
      rep = '0;
      if (r.kind == KIND_BYTE) begin
         if (r.rx_byte != next_byte) run_bad = run_bad + 32'd1;
         // resync on whatever arrived
         next_byte = r.rx_byte + 8'd1;
         run_bytes = run_bytes + 32'd1;
         // first byte of a run (also after the 32-bit count wraps) takes both
         // stamps; every 64th byte moves only the last stamp
         if (run_bytes == 32'd1) begin
            last_mark  = now_us;
            first_mark = now_us;
         end else if (run_bytes[STAMP_BITS-1:0] == '0) begin
            last_mark = now_us;
         end
         // window disabled: progress is frozen, not cleared
         if (cfg_model.ack_window != 16'd0) begin
            win_fill = win_fill + 16'd1;
            // >= so a window lowered under the progress acks on the next byte
            if (win_fill >= cfg_model.ack_window) begin
               win_fill = '0;
               rep.report_kind = REPORT_ACK;
               rep.total_bytes = run_bytes;
               return 1'b1;
            end
         end
         return 1'b0;
      end
      // tick: advance time first, then compare idle time with the limit
      now_us = now_us + 32'd1;
      idle = now_us - last_mark;
      run_over = (run_bytes != 32'd0) ? (idle > cfg_model.quiet_limit)
                                      : (idle > cfg_model.dead_limit);
      if (!run_over) return 1'b0;
      rep.report_kind   = REPORT_END;
      rep.total_bytes   = run_bytes;
      rep.elapsed_ticks = last_mark - first_mark;
      rep.mismatches    = run_bad;
      // clear the run; time keeps counting and the idle reference restarts
      next_byte  = '0;
      run_bytes  = '0;
      run_bad    = '0;
      win_fill   = '0;
      first_mark = '0;
      last_mark  = now_us;
      return 1'b1;
   endfunction

   task automatic report_error(input string what, input logic [31:0] got,
                               input logic [31:0] want);
      $display("ERROR at %0t: %s got %h want %h", $time, what, got, want);
      error_count++;
   endtask

   // ---------------------------------------------------------------------
   // Request driver: bursts of random length with random gaps, some long
   // bursts with no gap at all. valid holds until the request is taken.
   // ---------------------------------------------------------------------
   int unsigned burst_left = 0;
   int unsigned gap_left = 0;

   always @(posedge clock) begin : drive_requests
      csl_result_type rep;
      if (reset) begin
         req_ch.valid <= 1'b0;
         burst_left <= 0;
         gap_left <= 0;
      end else begin
         // the request on the bus is always the head of the queue
         if (req_ch.valid && req_ch.ready) begin
            if (predict_report(pending_reqs[0], rep)) reports_due.push_back(rep);
            void'(pending_reqs.pop_front());
         end
         if (req_ch.valid && !req_ch.ready) begin
            // stalled: keep offering the same request
         end else if (gap_left != 0) begin
            gap_left <= gap_left - 1;
            req_ch.valid <= 1'b0;
         end else if (pending_reqs.size() != 0) begin
            req_ch.valid   <= 1'b1;
            req_ch.kind    <= pending_reqs[0].kind;
            req_ch.rx_byte <= pending_reqs[0].rx_byte;
            if (burst_left <= 1) begin
               burst_left <= ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                         : $urandom_range(1, 24);
               gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Receiver ready: cycles through always-ready, coin-flip, mostly-stalled
   // and mostly-ready stretches. Once armed, it also holds off for the LONG_HOLD
   // hold-off so the result register fills and req_ch backs up.
   // ---------------------------------------------------------------------
   int unsigned rx_cycle = 0;
   int unsigned hold_left = 0;
   bit          hold_armed = 1'b0;
   bit          hold_done = 1'b0;

   always @(posedge clock) begin : drive_ready
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (hold_armed && !hold_done) begin
         hold_done <= 1'b1;
         hold_left <= LONG_HOLD;
         rsp_ch.ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ch.ready <= 1'b0;
      end else begin
         rx_cycle <= rx_cycle + 1;
         case ((rx_cycle / 64) % 4)
            0: rsp_ch.ready <= 1'b1;
            1: rsp_ch.ready <= 1'($urandom_range(0, 1));
            2: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
            default: rsp_ch.ready <= ($urandom_range(0, 7) != 0);
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Report monitor: every taken report is matched against the oldest
   // prediction, field by field.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : check_reports
      csl_result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (reports_due.size() == 0) begin
            report_error("report with none due, total_bytes", rsp_ch.total_bytes, '0);
         end else begin
            want = reports_due.pop_front();
            if (rsp_ch.report_kind != want.report_kind)
               report_error("report_kind", 32'(rsp_ch.report_kind),
                            32'(want.report_kind));
            if (rsp_ch.total_bytes != want.total_bytes)
               report_error("total_bytes", rsp_ch.total_bytes, want.total_bytes);
            if (rsp_ch.elapsed_ticks != want.elapsed_ticks)
               report_error("elapsed_ticks", rsp_ch.elapsed_ticks, want.elapsed_ticks);
            if (rsp_ch.mismatches != want.mismatches)
               report_error("mismatches", rsp_ch.mismatches, want.mismatches);
         end
      end
   end

   // Watchdog: any handshake on any channel counts as progress.
   int unsigned stuck_cycles = 0;

   always @(posedge clock) begin : watchdog
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
          || (csr_ch.valid && csr_ch.ready)) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------
   function automatic void send_byte(input logic [7:0] b);
      pending_reqs.push_back('{kind: KIND_BYTE, rx_byte: b});
      reqs_queued++;
   endfunction

   // the byte lane carries noise on ticks; the block must ignore it
   function automatic void send_tick();
      pending_reqs.push_back('{kind: KIND_TICK, rx_byte: 8'($urandom)});
      reqs_queued++;
   endfunction

   // One run: mostly an incrementing pattern with the odd corrupted byte and
   // a few ticks in between, then enough idle ticks to (usually) end it.
   function automatic void queue_run(input int unsigned nbytes,
                                     input int unsigned tail_ticks);
      logic [7:0] v;
      v = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'h00;
      for (int i = 0; i < nbytes; i++) begin
         if ($urandom_range(0, 19) == 0) v = 8'($urandom);
         send_byte(v);
         v = v + 8'd1;
         if ($urandom_range(0, 7) == 0) repeat ($urandom_range(1, 3)) send_tick();
      end
      repeat (tail_ticks) send_tick();
   endfunction

   // Registers are only written with nothing in flight. The predicted copy
   // is updated at the same edge the write is taken.
   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx, input logic [31:0] value);
      @(posedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= value;
      do @(posedge clock); while (!csr_ch.ready);
      case (idx)
         CSR_ACK_WINDOW:  cfg_model.ack_window  = value[15:0];
         CSR_QUIET_LIMIT: cfg_model.quiet_limit = value;
         CSR_DEAD_LIMIT:  cfg_model.dead_limit  = value;
         default: ;   // spare index: dropped
      endcase
      csr_ch.valid <= 1'b0;
   endtask

   // Waits until every request is taken and every report has come back, then
   // lets the last request, which may produce no report, pass the result register.
   task automatic wait_idle();
      do @(negedge clock);
      while (pending_reqs.size() != 0 || req_ch.valid || reports_due.size() != 0);
      repeat (2) @(negedge clock);
   endtask

   // One random phase: new register settings, then a few runs. The pressure
   // phase forces a tiny window so acks pile up behind the long hold-off.
   task automatic random_phase(input bit long_hold);
      logic [15:0] win;
      logic [31:0] quiet, dead;
      int unsigned tail;
      case ($urandom_range(0, 5))
         0: win = 16'd0;
         1: win = 16'hFFFF;
         2: win = 16'($urandom_range(17, 200));
         default: win = 16'($urandom_range(1, 16));
      endcase
      case ($urandom_range(0, 7))
         0: quiet = 32'd0;
         1: quiet = LIMIT_MAX;
         2: quiet = $urandom_range(65, 150);
         default: quiet = $urandom_range(1, 64);
      endcase
      case ($urandom_range(0, 7))
         0: dead = 32'd0;
         1: dead = LIMIT_MAX;
         2: dead = $urandom_range(65, 150);
         default: dead = $urandom_range(1, 64);
      endcase
      if (long_hold) win = 16'd2;
      // upper bits of the window write are junk the block has to mask off
      write_csr(CSR_ACK_WINDOW, {16'($urandom), win});
      write_csr(CSR_QUIET_LIMIT, quiet);
      write_csr(CSR_DEAD_LIMIT, dead);
      if ($urandom_range(0, 3) == 0) write_csr(CSR_SPARE, $urandom);
      @(negedge clock);
      if (long_hold) hold_armed = 1'b1;
      repeat ($urandom_range(1, 4)) begin
         // noise: random kinds and bytes
         if ($urandom_range(0, 9) == 0) begin
            repeat (10) begin
               if ($urandom_range(0, 1) != 0) send_tick();
               else send_byte(8'($urandom));
            end
         end
         tail = (quiet <= 150) ? quiet + $urandom_range(1, 3) : $urandom_range(5, 30);
         queue_run(($urandom_range(0, 5) == 0) ? $urandom_range(64, 200)
                                               : $urandom_range(1, 40), tail);
      end
      // idle with no bytes in the run: exercises the dead limit
      if (dead <= 150 && $urandom_range(0, 1) != 0) repeat (dead + 2) send_tick();
      wait_idle();
   endtask

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin : main_sequence
      int unsigned phase;
      int unsigned directed_reqs;
      csr_ch.valid   = 1'b0;
      csr_ch.index   = CSR_ACK_WINDOW;
      csr_ch.data    = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: window off, limits far away, so no report is due.
      // Pattern from 0x00, then 0xFF out of order, 0x00 after it (mismatch
      // counted, then resync), and 0x80 as a second mismatch.
      @(negedge clock);
      send_byte(8'h00);
      send_byte(8'h01);
      send_byte(8'h02);
      send_byte(8'hFF);
      send_byte(8'h00);
      send_byte(8'h80);
      send_tick();
      wait_idle();

      // Window of one and zero limits: every byte acks, the first tick ends
      // the run, and the next tick ends an empty run on the dead limit.
      write_csr(CSR_ACK_WINDOW, 32'd1);
      write_csr(CSR_QUIET_LIMIT, 32'd0);
      write_csr(CSR_DEAD_LIMIT, 32'd0);
      @(negedge clock);
      send_byte(8'h81);
      send_tick();
      send_tick();
      wait_idle();

      // Maximum limits (runs never end), window of three; spare index write.
      write_csr(CSR_ACK_WINDOW, 32'd3);
      write_csr(CSR_QUIET_LIMIT, LIMIT_MAX);
      write_csr(CSR_DEAD_LIMIT, LIMIT_MAX);
      write_csr(CSR_SPARE, 32'h0000_0007);
      @(negedge clock);
      for (int i = 0; i < 5; i++) send_byte(8'(i));
      wait_idle();

      // Window dropped below the current progress, upper bits masked: the
      // very next byte acks.
      write_csr(CSR_ACK_WINDOW, 32'hFFFF_0001);
      @(negedge clock);
      send_byte(8'h05);
      send_tick();
      wait_idle();

      // Largest window, limits of one: the run ends on the first tick, the empty run that follows on the third.
      write_csr(CSR_ACK_WINDOW, 32'h0000_FFFF);
      write_csr(CSR_QUIET_LIMIT, 32'd1);
      write_csr(CSR_DEAD_LIMIT, 32'd1);
      @(negedge clock);
      send_byte(8'h06);
      repeat (4) send_tick();
      wait_idle();

      // Random phases until the request budget is spent; phase 3 carries the
      // long receiver hold-off.
      directed_reqs = reqs_queued;
      phase = 0;
      while (reqs_queued < directed_reqs + RANDOM_REQS) begin
         random_phase(phase == 3);
         phase++;
      end

      wait_idle();
      repeat (4) @(negedge clock);
      if (error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
